@@ hw/rtl/cps_pkg.sv @@
// Package for the credit priority scheduler: payload structs, command codes,
// control word layout and the microcode table. No dependencies.

package cps_pkg;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] slot;
		logic [7:0] value;
	} cps_in_t;

	typedef struct packed {
		logic [3:0] selected_slot;
		logic       idle;
		logic       refilled;
	} cps_out_t;

	localparam logic [1:0] CMD_SCHED   = 2'd0;
	localparam logic [1:0] CMD_WR_BASE = 2'd1;
	localparam logic [1:0] CMD_WR_BLK  = 2'd2;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SSTART = 4'd1;
	localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_CHK1   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_RSTART = 4'd4;
	localparam logic [STEP_W-1:0] STEP_RSCAN  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_CHK2   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RESULT = 4'd7;
	localparam logic [STEP_W-1:0] STEP_DEC    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_WRBASE = 4'd9;
	localparam logic [STEP_W-1:0] STEP_WRBLK  = 4'd10;

	// How the step counter moves after the current control word.
	typedef enum logic [2:0] {
		SQ_NEXT,
		SQ_JUMP,
		SQ_DISPATCH,
		SQ_LOOP,
		SQ_FOUND,
		SQ_OUTWAIT
	} cps_seq_t;

	typedef struct packed {
		logic              take_in;
		logic              scan_clr;
		logic              scan_run;
		logic              use_base;
		logic              set_refill;
		logic              set_idle_nf;
		logic              dec;
		logic              wr_base;
		logic              wr_blk;
		logic              load_out;
		cps_seq_t          seq;
		logic [STEP_W-1:0] target;
	} cps_ctrl_t;

	typedef struct packed {
		logic       in_fire;
		logic [1:0] command;
		logic       scan_done;
		logic       found;
		logic       out_free;
	} cps_stat_t;

	function automatic cps_ctrl_t mc_word(logic [STEP_W-1:0] step);
		cps_ctrl_t w;
		w = '0;
		w.seq = SQ_NEXT;
		w.target = STEP_WAIT;
		case (step)
			STEP_WAIT: begin
				w.take_in = 1'b1;
				w.seq = SQ_DISPATCH;
			end
			STEP_SSTART: begin
				w.scan_clr = 1'b1;
			end
			STEP_SCAN: begin
				w.scan_run = 1'b1;
				w.seq = SQ_LOOP;
			end
			STEP_CHK1: begin
				w.seq = SQ_FOUND;
				w.target = STEP_DEC;
			end
			STEP_RSTART: begin
				w.scan_clr = 1'b1;
				w.set_refill = 1'b1;
			end
			STEP_RSCAN: begin
				w.scan_run = 1'b1;
				w.use_base = 1'b1;
				w.seq = SQ_LOOP;
			end
			STEP_CHK2: begin
				w.set_idle_nf = 1'b1;
				w.seq = SQ_FOUND;
				w.target = STEP_DEC;
			end
			STEP_RESULT: begin
				w.load_out = 1'b1;
				w.seq = SQ_OUTWAIT;
				w.target = STEP_WAIT;
			end
			STEP_DEC: begin
				w.dec = 1'b1;
				w.seq = SQ_JUMP;
				w.target = STEP_RESULT;
			end
			STEP_WRBASE: begin
				w.wr_base = 1'b1;
				w.seq = SQ_JUMP;
				w.target = STEP_RESULT;
			end
			STEP_WRBLK: begin
				w.wr_blk = 1'b1;
				w.seq = SQ_JUMP;
				w.target = STEP_RESULT;
			end
			default: begin
				w.seq = SQ_JUMP;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/cps_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module cps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/cps_seq.sv @@
// Microcode sequencer of the credit priority scheduler: step counter, control
// word lookup and conditional jumps. Depends on cps_pkg.

module cps_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  cps_pkg::cps_stat_t  stat,
	output cps_pkg::cps_ctrl_t  ctrl
);

	logic [cps_pkg::STEP_W-1:0] step_q;
	logic [cps_pkg::STEP_W-1:0] step_d;
	cps_pkg::cps_ctrl_t         cw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cps_pkg::STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		cw = cps_pkg::mc_word(step_q);
		step_d = step_q;
		case (cw.seq)
			cps_pkg::SQ_NEXT: step_d = step_q + 4'd1;
			cps_pkg::SQ_JUMP: step_d = cw.target;
			cps_pkg::SQ_DISPATCH: begin
				if (stat.in_fire) begin
					case (stat.command)
						cps_pkg::CMD_SCHED:   step_d = cps_pkg::STEP_SSTART;
						cps_pkg::CMD_WR_BASE: step_d = cps_pkg::STEP_WRBASE;
						cps_pkg::CMD_WR_BLK:  step_d = cps_pkg::STEP_WRBLK;
						default:              step_d = cps_pkg::STEP_RESULT;
					endcase
				end
			end
			cps_pkg::SQ_LOOP: step_d = stat.scan_done ? step_q + 4'd1 : step_q;
			cps_pkg::SQ_FOUND: step_d = stat.found ? cw.target : step_q + 4'd1;
			cps_pkg::SQ_OUTWAIT: step_d = stat.out_free ? cw.target : step_q;
			default: step_d = cps_pkg::STEP_WAIT;
		endcase
		ctrl = cw;
	end

endmodule

@@ hw/rtl/credit_priority_scheduler_unit.sv @@
// Top level of the credit priority scheduler: slot stores, scan datapath and
// result register. Depends on cps_pkg, cps_ram and cps_seq.
//
//   channel | signals                     | payload
//   --------+-----------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data | cps_in_t: command, slot, value
//   output  | out_valid, out_ready, out_data | cps_out_t: slot, idle, refilled
//
// A schedule command runs a scan pass from acceptance to result, plus a
// refill pass when one is needed (without the credit decrement when it ends
// idle); each pass reads one slot a cycle from the slot RAMs. Writes and the
// unused command run no pass.
// After reset every store reads as zero through per-entry valid flops, so no
// clearing pass is run. A new transaction is taken while a result waits in
// the output register; the result step stalls only if that register is full.

module credit_priority_scheduler_unit #(
	parameter int NUM_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cps_pkg::cps_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cps_pkg::cps_out_t out_data
);

	localparam int AW    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	cps_pkg::cps_ctrl_t ctrl;
	cps_pkg::cps_stat_t stat;

	cps_pkg::cps_in_t  in_q;
	cps_pkg::cps_out_t out_q;
	logic              out_valid_q;

	logic [CNT_W-1:0] cnt_q;
	logic             rd_pend_s1;
	logic [AW-1:0]    rd_addr_s1;
	logic [AW-1:0]    rd_addr;
	logic             scan_done;

	logic [7:0]    top_q;
	logic [AW-1:0] best_q;
	logic          found_q;
	logic          idle_q;
	logic          refill_q;

	logic [NUM_SLOTS-1:0] cred_vld_q;
	logic [NUM_SLOTS-1:0] base_vld_q;
	logic [NUM_SLOTS-1:0] blk_vld_q;

	logic [7:0] cred_dout;
	logic [7:0] base_dout;
	logic [0:0] blk_dout;
	logic [7:0] cred_rd;
	logic [7:0] base_rd;
	logic       blk_rd;
	logic [7:0] cand;
	logic       better;

	logic          cred_we;
	logic [AW-1:0] cred_waddr;
	logic [7:0]    cred_wdata;
	logic          base_we;
	logic          blk_we;

	logic [6:0]    slot_x;
	logic          slot_ok;
	logic [AW-1:0] wr_slot;
	logic [6:0]    best_x;
	logic          in_fire;
	logic          out_free;

	cps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign in_ready  = ctrl.take_in;
	assign in_fire   = in_valid & ctrl.take_in;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_done = (cnt_q == CNT_W'(NUM_SLOTS));

	always_comb begin
		stat.in_fire   = in_fire;
		stat.command   = in_data.command;
		stat.scan_done = scan_done;
		stat.found     = found_q;
		stat.out_free  = out_free;
	end

	assign slot_x  = {3'b000, in_q.slot};
	assign slot_ok = (slot_x < 7'(NUM_SLOTS));
	assign wr_slot = slot_x[AW-1:0];
	assign best_x  = 7'(best_q);
	assign rd_addr = cnt_q[AW-1:0];

	// Entries never written read as zero, matching the reset state.
	always_comb begin
		cred_rd = cred_vld_q[rd_addr_s1] ? cred_dout : 8'd0;
		base_rd = base_vld_q[rd_addr_s1] ? base_dout : 8'd0;
		blk_rd  = blk_vld_q[rd_addr_s1] ? blk_dout[0] : 1'b0;
		cand    = ctrl.use_base ? base_rd : cred_rd;
		better  = rd_pend_s1 && !blk_rd && (cand > top_q);
	end

	// In the refill pass the credit of each runnable slot is reloaded as it
	// is compared, so the second pick runs in the same pass.
	always_comb begin
		cred_we    = 1'b0;
		cred_waddr = rd_addr_s1;
		cred_wdata = base_rd;
		if (ctrl.dec) begin
			cred_we    = 1'b1;
			cred_waddr = best_q;
			cred_wdata = top_q - 8'd1;
		end else if (rd_pend_s1 && ctrl.use_base && !blk_rd) begin
			cred_we = 1'b1;
		end
		base_we = ctrl.wr_base && slot_ok;
		blk_we  = ctrl.wr_blk && slot_ok;
	end

	cps_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_cred_ram (
		.clk   (clk),
		.we    (cred_we),
		.waddr (cred_waddr),
		.wdata (cred_wdata),
		.raddr (rd_addr),
		.rdata (cred_dout)
	);

	cps_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (wr_slot),
		.wdata (in_q.value),
		.raddr (rd_addr),
		.rdata (base_dout)
	);

	cps_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (wr_slot),
		.wdata (in_q.value[0]),
		.raddr (rd_addr),
		.rdata (blk_dout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_vld_q <= '0;
			base_vld_q <= '0;
			blk_vld_q  <= '0;
		end else begin
			if (cred_we) begin
				cred_vld_q[cred_waddr] <= 1'b1;
			end
			if (base_we) begin
				base_vld_q[wr_slot] <= 1'b1;
			end
			if (blk_we) begin
				blk_vld_q[wr_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_data;
		end
		rd_addr_s1 <= rd_addr;
		if (ctrl.scan_clr || in_fire) begin
			top_q  <= 8'd0;
			best_q <= '0;
		end else if (better) begin
			top_q  <= cand;
			best_q <= rd_addr_s1;
		end
		if (ctrl.load_out && out_free) begin
			out_q.selected_slot <= found_q ? best_x[3:0] : 4'd0;
			out_q.idle          <= idle_q;
			out_q.refilled      <= refill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			found_q     <= 1'b0;
			idle_q      <= 1'b0;
			refill_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= ctrl.scan_run && !scan_done;
			if (ctrl.scan_clr) begin
				cnt_q <= '0;
			end else if (ctrl.scan_run && !scan_done) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.scan_clr || in_fire) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
			if (in_fire) begin
				idle_q   <= 1'b0;
				refill_q <= 1'b0;
			end else begin
				if (ctrl.set_idle_nf && !found_q) begin
					idle_q <= 1'b1;
				end
				if (ctrl.set_refill) begin
					refill_q <= 1'b1;
				end
			end
			if (ctrl.load_out && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
